>>> sv/rotating_key_value_lookaside_defines.svh
// Assertion macros shared by the lookaside RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ROTATING_KEY_VALUE_LOOKASIDE_DEFINES_SVH
`define ROTATING_KEY_VALUE_LOOKASIDE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RKVL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RKVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rkvl_pkg.sv
// Shared constants, command codes and the token type of the lookaside chain.
// No dependencies; imported by the interfaces, the cell and the top level.
package rkvl_pkg;

  localparam int ENTRIES = 16;
  localparam int PTR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // Request token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [PTR_W-1:0] ptr;          // cells left until the append slot
    logic             hit;          // an earlier cell already handled it
    logic [VAL_W-1:0] found_value;
  } token_t;

endpackage

>>> sv/rkvl_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on rkvl_pkg for field widths.
interface rkvl_in_if import rkvl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, cmd, key, new_value, input ready);
  modport sink   (input valid, cmd, key, new_value, output ready);
endinterface

interface rkvl_out_if import rkvl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] found_value;

  modport source (output valid, found, found_value, input ready);
  modport sink   (input valid, found, found_value, output ready);
endinterface

>>> sv/rkvl_cell.sv
// One entry of the lookaside store plus its stage of the request chain.
// Depends on rkvl_pkg (token_t, command codes).
module rkvl_cell import rkvl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  token_t tok_in,
  output token_t tok_out
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  token_t           tok_r, tok_nxt;
  logic             is_app, is_find, is_rem, match;

  // Match and update for the token passing this cell
  always_comb begin
    is_app  = (tok_in.cmd == CMD_APPEND);
    is_find = (tok_in.cmd == CMD_FIND);
    is_rem  = (tok_in.cmd == CMD_REMOVE);
    match   = tok_in.valid && !tok_in.hit &&
              ((is_app && (tok_in.ptr == '0)) ||
               ((is_find || is_rem) && (key_r == tok_in.key)));

    tok_nxt     = tok_in;
    tok_nxt.ptr = tok_in.ptr - PTR_W'(1);
    tok_nxt.hit = tok_in.hit | match;
    if (match && is_find) begin
      tok_nxt.found_value = val_r;
    end

    key_nxt = key_r;
    val_nxt = val_r;
    if (match && is_app) begin
      key_nxt = tok_in.key;
      val_nxt = tok_in.value;
    end else if (match && is_rem) begin
      key_nxt = '1;
      val_nxt = '1;
    end
  end

  // Entry resets to empty (all ones)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '1;
      val_r <= '1;
      tok_r <= '0;
    end else begin
      key_r <= key_nxt;
      val_r <= val_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> sv/rotating_key_value_lookaside.sv
// Fully associative key/value lookaside, round-robin append, as a chain of entry cells.
// A request's token passes through every cell register, then the output register or skid, before its result is offered.
// A new request is accepted only once the previous token has walked every cell once and left the chain.
// One unread result waits in the output register; a second one fills the skid and stalls input.
// Reset (synchronous, rst_n low): all entries empty (all ones), write pointer zero, idle.
// Depends on rkvl_pkg, rkvl_if, rkvl_cell and the assertion macro header.
`include "rotating_key_value_lookaside_defines.svh"

module rotating_key_value_lookaside import rkvl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rkvl_in_if.sink  in_chan,
  rkvl_out_if.source out_chan
);

  token_t             tok [ENTRIES+1];
  token_t             tok_head;
  logic [ENTRIES:0]   tok_valid_vec;
  logic               busy_r, busy_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic               accept, take;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VAL_W-1:0]   out_value_r, out_value_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic               skid_found_r, skid_found_nxt;
  logic [VAL_W-1:0]   skid_value_r, skid_value_nxt;
  logic               res_found;

  assign in_chan.ready = !busy_r && !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign take          = out_valid_r && out_chan.ready;

  // Inject the request token at the head of the chain
  always_comb begin
    tok_head             = '0;
    tok_head.valid       = accept;
    tok_head.cmd         = in_chan.cmd;
    tok_head.key         = in_chan.key;
    tok_head.value       = in_chan.new_value;
    tok_head.ptr         = wp_r;
  end

  assign tok[0] = tok_head;

  // Entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rkvl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
    assign tok_valid_vec[i] = tok[i].valid;
  end

  assign res_found = tok[ENTRIES].hit && (tok[ENTRIES].cmd != CMD_APPEND);

  // Busy flag, write pointer and result registers
  always_comb begin
    busy_nxt       = busy_r;
    wp_nxt         = wp_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    skid_value_nxt = skid_value_r;

    if (accept) begin
      busy_nxt = 1'b1;
      if (in_chan.cmd == CMD_APPEND) begin
        wp_nxt = (wp_r == PTR_W'(ENTRIES - 1)) ? '0 : wp_r + PTR_W'(1);
      end
    end
    if (tok[ENTRIES].valid) begin
      busy_nxt = 1'b0;
    end

    // Output register drains first, skid refills it
    if (take) begin
      if (skid_valid_r) begin
        out_found_nxt  = skid_found_r;
        out_value_nxt  = skid_value_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end
    if (tok[ENTRIES].valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = res_found;
        out_value_nxt  = tok[ENTRIES].found_value;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_found_nxt = res_found;
        skid_value_nxt = tok[ENTRIES].found_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      wp_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      wp_r         <= wp_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    skid_found_r <= skid_found_nxt;
    skid_value_r <= skid_value_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.found_value = out_value_r;

  // Checks
  `RKVL_ASSERT_NEXT(a_busy_after_accept, accept, busy_r, "busy not set after request")
  `RKVL_ASSERT_NOW(a_tail_only_when_busy, tok[ENTRIES].valid, busy_r, "stray token at chain end")
  `RKVL_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_valid_vec) <= 1, "two tokens in chain")
  `RKVL_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full, output empty")

endmodule

>>> sim/lookaside_checker.sv
`timescale 1ns / 100ps
// Checker for the key/value lookaside: mirrors the entry store and write slot,
// predicts every result transaction and compares it. Depends on rkvl_pkg, rkvl_if.
module lookaside_checker import rkvl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rkvl_in_if   req_mon,
  rkvl_out_if  rsp_mon,
  output int   error_count,
  output int   answers_pending
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } answer_t;

  localparam slot_t EMPTY_SLOT = '1;

  slot_t   slots [ENTRIES];
  int      next_slot;
  answer_t pending_answers [$];

  initial error_count = 0;
  initial answers_pending = 0;

  // Apply one request to the mirrored store and return its answer
  function automatic answer_t apply_request(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] value);
    answer_t ans;
    int      hit;
    ans = '0;
    hit = -1;
    // lowest-numbered match wins; empty slots match a key of all ones
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (slots[i].key == key) hit = i;
    case (op)
      CMD_APPEND: begin
        slots[next_slot] = '{value: value, key: key};
        next_slot = (next_slot + 1) % ENTRIES;
      end
      CMD_FIND: begin
        if (hit >= 0) begin
          ans.found = 1'b1;
          ans.value = slots[hit].value;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          slots[hit] = EMPTY_SLOT;
          ans.found  = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic flag_error(string what, answer_t want);
    if (error_count < 10)
      $display("%0t: %s: expected found=%0b value=%h, got found=%0b value=%h",
               $realtime, what, want.found, want.value, rsp_mon.found,
               rsp_mon.found_value);
    error_count++;
  endtask

  // Retire results first, then record the new request's answer
  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      foreach (slots[i]) slots[i] = EMPTY_SLOT;
      next_slot = 0;
      pending_answers.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_answers.size() == 0) begin
          flag_error("result with nothing outstanding", '0);
        end else begin
          want = pending_answers.pop_front();
          if (rsp_mon.found !== want.found || rsp_mon.found_value !== want.value)
            flag_error("result mismatch", want);
        end
      end
      if (req_mon.valid && req_mon.ready)
        pending_answers.push_back(apply_request(req_mon.cmd, req_mon.key,
                                                req_mon.new_value));
    end
    answers_pending = pending_answers.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the lookaside testbench: clock, reset, request stimulus, result stalls
// and the verdict. Depends on rkvl_pkg, rkvl_if, the block and lookaside_checker.
module testbench import rkvl_pkg::*;;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic [KEY_W-1:0] ALL_ONES = '1;

  logic clk;
  logic rst_n;
  int   error_count;
  int   answers_pending;
  int   idle_cycles;

  logic [KEY_W-1:0] key_pool [24];

  rkvl_in_if  req_chan ();
  rkvl_out_if rsp_chan ();

  rotating_key_value_lookaside uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  lookaside_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_mon         (req_chan),
    .rsp_mon         (rsp_chan),
    .error_count     (error_count),
    .answers_pending (answers_pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one request at the falling edge and hold it until accepted
  task automatic send_request(input cmd_t op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    req_chan.valid     = 1'b1;
    req_chan.cmd       = op;
    req_chan.key       = key;
    req_chan.new_value = value;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    req_chan.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Mostly pooled keys so finds and removes hit; some all ones, some fully random
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, 23)];
    if (r < 86) return ALL_ONES;
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_APPEND;
    if (r < 75) return CMD_FIND;
    return CMD_REMOVE;
  endfunction

  // Result side stall pattern: free-running, random, or long stall runs
  int ready_mode;
  int mode_left;
  int stall_left;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (ready_mode)
      0: rsp_chan.ready = 1'b1;
      1: rsp_chan.ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          rsp_chan.ready = 1'b0;
          stall_left--;
        end else begin
          rsp_chan.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
        end
      end
    endcase
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    cmd_t op;
    rst_n              = 1'b0;
    idle_cycles        = 0;
    ready_mode         = 0;
    mode_left          = 0;
    stall_left         = 0;
    req_chan.valid     = 1'b0;
    req_chan.cmd       = CMD_APPEND;
    req_chan.key       = '0;
    req_chan.new_value = '0;
    rsp_chan.ready     = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty-entry matches, misses, extremes, duplicates, lowest match
    send_request(CMD_FIND,   ALL_ONES, 32'h0000_0000);  // matches an empty entry
    send_request(CMD_REMOVE, ALL_ONES, 32'hFFFF_FFFF);  // clears an already empty entry
    send_request(CMD_FIND,   32'h0,    32'h0);           // miss
    send_request(CMD_REMOVE, 32'h0,    32'h0);           // miss
    send_request(CMD_APPEND, 32'h0,    32'hFFFF_FFFF);
    send_request(CMD_APPEND, ALL_ONES, 32'h0);
    send_request(CMD_FIND,   32'h0,    32'h1234_5678);   // value field ignored
    send_request(CMD_FIND,   ALL_ONES, 32'h0);
    send_request(CMD_APPEND, 32'h5A5A_5A5A, 32'h1234_5678);
    send_request(CMD_APPEND, 32'h5A5A_5A5A, 32'h9ABC_DEF0);  // duplicate key
    send_request(CMD_FIND,   32'h5A5A_5A5A, 32'h0);      // lower entry wins
    send_request(CMD_REMOVE, 32'h5A5A_5A5A, 32'h0);
    send_request(CMD_FIND,   32'h5A5A_5A5A, 32'h0);      // now the duplicate
    send_request(CMD_REMOVE, 32'h0,    32'h0);
    send_request(CMD_FIND,   32'h0,    32'h0);
    send_request(CMD_FIND,   ALL_ONES, 32'h0);           // emptied entry 0 now first
    send_request(CMD_APPEND, 32'hFFFF_FFFE, 32'h0000_0001);
    send_request(CMD_FIND,   32'hFFFF_FFFE, 32'h0);
    send_request(CMD_APPEND, 32'hA5A5_A5A5, 32'h5555_AAAA);
    send_request(CMD_REMOVE, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    idle_sender(3);

    // Random bursts with random gaps; some back-to-back stretches
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
        op = pick_cmd();
        send_request(op, pick_key(), pick_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 30));
    end
    req_chan.valid = 1'b0;

    // Drain outstanding results, then let any stray result show up
    while (answers_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rkvl_pkg.sv
sv/rkvl_if.sv
sv/rkvl_cell.sv
sv/rotating_key_value_lookaside.sv
sim/lookaside_checker.sv
sim/testbench.sv
